// ===== sv/fbpa_pkg.sv =====
// Package with pool geometry, status codes and command codes for the block pool allocator
package fbpa_pkg;

  localparam int SMALL_BLOCKS  = 8;
  localparam int MEDIUM_BLOCKS = 8;
  localparam int LARGE_BLOCKS  = 4;
  localparam int HEADER_BYTES  = 4;

  localparam int SMALL_SIZE  = 16;
  localparam int MEDIUM_SIZE = 32;
  localparam int LARGE_SIZE  = 64;

  localparam int SMALL_SHIFT  = $clog2(SMALL_SIZE);
  localparam int MEDIUM_SHIFT = $clog2(MEDIUM_SIZE);
  localparam int LARGE_SHIFT  = $clog2(LARGE_SIZE);

  localparam int SMALL_AREA  = SMALL_BLOCKS * SMALL_SIZE;
  localparam int MEDIUM_AREA = MEDIUM_BLOCKS * MEDIUM_SIZE;
  localparam int LARGE_AREA  = LARGE_BLOCKS * LARGE_SIZE;
  localparam int MEDIUM_START = SMALL_AREA;
  localparam int LARGE_START  = SMALL_AREA + MEDIUM_AREA;
  localparam int TOTAL_AREA   = SMALL_AREA + MEDIUM_AREA + LARGE_AREA;

  localparam logic signed [15:0] SMALL_PAYLOAD  = 16'(SMALL_SIZE - HEADER_BYTES);
  localparam logic signed [15:0] MEDIUM_PAYLOAD = 16'(MEDIUM_SIZE - HEADER_BYTES);
  localparam logic signed [15:0] LARGE_PAYLOAD  = 16'(LARGE_SIZE - HEADER_BYTES);

  // block index and free count widths
  localparam int S_IW = (SMALL_BLOCKS > 1) ? $clog2(SMALL_BLOCKS) : 1;
  localparam int M_IW = (MEDIUM_BLOCKS > 1) ? $clog2(MEDIUM_BLOCKS) : 1;
  localparam int L_IW = (LARGE_BLOCKS > 1) ? $clog2(LARGE_BLOCKS) : 1;
  localparam int S_CW = $clog2(SMALL_BLOCKS + 1);
  localparam int M_CW = $clog2(MEDIUM_BLOCKS + 1);
  localparam int L_CW = $clog2(LARGE_BLOCKS + 1);

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EXHAUSTED = 3'd1,
    ST_TOO_LARGE = 3'd2,
    ST_BAD_ADDR  = 3'd3,
    ST_DOUBLE    = 3'd4
  } status_e;

endpackage

// ===== sv/fbpa_req_if.sv =====
// Request and response channel interfaces of the block pool allocator
interface fbpa_req_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic signed [15:0] request_size;
  logic        [15:0] release_address;

  modport source (output valid, output command, output request_size,
                  output release_address, input ready);
  modport sink   (input valid, input command, input request_size,
                  input release_address, output ready);
endinterface

interface fbpa_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] payload_address;
  logic [2:0]  status;

  modport source (output valid, output payload_address, output status, input ready);
  modport sink   (input valid, input payload_address, input status, output ready);
endinterface

// ===== sv/fixed_block_pool_allocator.sv =====
// Top level of the three-pool fixed block allocator
//
//  channel  | dir | transfer when         | payload
//  req_i    | in  | valid && ready        | command, request_size, release_address
//  rsp_o    | out | valid && ready        | payload_address, status
//  cfg      | in  | cfg_we_i high         | cfg_wdata_i -> base address
//
//  One request per cycle while the response is not stalled; a request enters
//  a request register, then the pool decode and stack pop or push go into
//  the response register. A response is valid once its request has passed
//  the request register and then the response register.
//  Reset fills every free stack with index 0 on top and clears all in-use bits.
//  A stalled response holds the response register, and the request register
//  if it holds a request; state changes only when a request moves into the response register.
module fixed_block_pool_allocator (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_wdata_i,
  fbpa_req_if.sink            req_i,
  fbpa_rsp_if.source          rsp_o
);

  logic [15:0] base_q;

  logic                   s1_valid_q;
  fbpa_pkg::cmd_e         cmd_q;
  logic signed [15:0]     size_q;
  logic [15:0]            rel_q;
  logic                   s1_adv;

  logic                   out_valid_q;
  logic [15:0]            addr_q, addr_d;
  fbpa_pkg::status_e      status_q, status_d;

  logic [fbpa_pkg::S_IW-1:0] small_stk_q [fbpa_pkg::SMALL_BLOCKS];
  logic [fbpa_pkg::S_IW-1:0] small_stk_d [fbpa_pkg::SMALL_BLOCKS];
  logic [fbpa_pkg::M_IW-1:0] med_stk_q   [fbpa_pkg::MEDIUM_BLOCKS];
  logic [fbpa_pkg::M_IW-1:0] med_stk_d   [fbpa_pkg::MEDIUM_BLOCKS];
  logic [fbpa_pkg::L_IW-1:0] large_stk_q [fbpa_pkg::LARGE_BLOCKS];
  logic [fbpa_pkg::L_IW-1:0] large_stk_d [fbpa_pkg::LARGE_BLOCKS];

  logic [fbpa_pkg::S_CW-1:0] small_cnt_q, small_cnt_d, small_pop;
  logic [fbpa_pkg::M_CW-1:0] med_cnt_q, med_cnt_d, med_pop;
  logic [fbpa_pkg::L_CW-1:0] large_cnt_q, large_cnt_d, large_pop;

  logic [fbpa_pkg::SMALL_BLOCKS-1:0]  small_used_q, small_used_d;
  logic [fbpa_pkg::MEDIUM_BLOCKS-1:0] med_used_q, med_used_d;
  logic [fbpa_pkg::LARGE_BLOCKS-1:0]  large_used_q, large_used_d;

  logic [fbpa_pkg::S_IW-1:0] small_top, small_fidx;
  logic [fbpa_pkg::M_IW-1:0] med_top, med_fidx;
  logic [fbpa_pkg::L_IW-1:0] large_top, large_fidx;

  logic [15:0] off, off_m, off_l;
  logic        in_small, in_med, in_large;

  assign s1_adv      = !out_valid_q || rsp_o.ready;
  assign req_i.ready = !s1_valid_q || s1_adv;

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.payload_address = addr_q;
  assign rsp_o.status          = status_q;

  assign small_pop = small_cnt_q - fbpa_pkg::S_CW'(1);
  assign med_pop   = med_cnt_q - fbpa_pkg::M_CW'(1);
  assign large_pop = large_cnt_q - fbpa_pkg::L_CW'(1);
  assign small_top = small_stk_q[small_pop[fbpa_pkg::S_IW-1:0]];
  assign med_top   = med_stk_q[med_pop[fbpa_pkg::M_IW-1:0]];
  assign large_top = large_stk_q[large_pop[fbpa_pkg::L_IW-1:0]];

  assign off      = rel_q - base_q - 16'(fbpa_pkg::HEADER_BYTES);
  assign off_m    = off - 16'(fbpa_pkg::MEDIUM_START);
  assign off_l    = off - 16'(fbpa_pkg::LARGE_START);
  assign in_small = off < 16'(fbpa_pkg::SMALL_AREA);
  assign in_med   = off < 16'(fbpa_pkg::LARGE_START);
  assign in_large = off < 16'(fbpa_pkg::TOTAL_AREA);

  assign small_fidx = fbpa_pkg::S_IW'(off >> fbpa_pkg::SMALL_SHIFT);
  assign med_fidx   = fbpa_pkg::M_IW'(off_m >> fbpa_pkg::MEDIUM_SHIFT);
  assign large_fidx = fbpa_pkg::L_IW'(off_l >> fbpa_pkg::LARGE_SHIFT);

  always_comb begin
    small_stk_d  = small_stk_q;
    med_stk_d    = med_stk_q;
    large_stk_d  = large_stk_q;
    small_cnt_d  = small_cnt_q;
    med_cnt_d    = med_cnt_q;
    large_cnt_d  = large_cnt_q;
    small_used_d = small_used_q;
    med_used_d   = med_used_q;
    large_used_d = large_used_q;
    addr_d       = '0;
    status_d     = fbpa_pkg::ST_OK;

    case (cmd_q)
      fbpa_pkg::CMD_ALLOC: begin
        if (size_q <= fbpa_pkg::SMALL_PAYLOAD) begin
          if (small_cnt_q == '0) begin
            status_d = fbpa_pkg::ST_EXHAUSTED;
          end else begin
            small_cnt_d             = small_pop;
            small_used_d[small_top] = 1'b1;
            addr_d = base_q + 16'(fbpa_pkg::HEADER_BYTES)
                   + (16'(small_top) << fbpa_pkg::SMALL_SHIFT);
          end
        end else if (size_q <= fbpa_pkg::MEDIUM_PAYLOAD) begin
          if (med_cnt_q == '0) begin
            status_d = fbpa_pkg::ST_EXHAUSTED;
          end else begin
            med_cnt_d           = med_pop;
            med_used_d[med_top] = 1'b1;
            addr_d = base_q + 16'(fbpa_pkg::MEDIUM_START + fbpa_pkg::HEADER_BYTES)
                   + (16'(med_top) << fbpa_pkg::MEDIUM_SHIFT);
          end
        end else if (size_q <= fbpa_pkg::LARGE_PAYLOAD) begin
          if (large_cnt_q == '0) begin
            status_d = fbpa_pkg::ST_EXHAUSTED;
          end else begin
            large_cnt_d             = large_pop;
            large_used_d[large_top] = 1'b1;
            addr_d = base_q + 16'(fbpa_pkg::LARGE_START + fbpa_pkg::HEADER_BYTES)
                   + (16'(large_top) << fbpa_pkg::LARGE_SHIFT);
          end
        end else begin
          status_d = fbpa_pkg::ST_TOO_LARGE;
        end
      end
      fbpa_pkg::CMD_FREE: begin
        if (in_small) begin
          if ((off & 16'(fbpa_pkg::SMALL_SIZE - 1)) != '0) begin
            status_d = fbpa_pkg::ST_BAD_ADDR;
          end else if (!small_used_q[small_fidx] ||
                       small_cnt_q >= fbpa_pkg::S_CW'(fbpa_pkg::SMALL_BLOCKS)) begin
            status_d = fbpa_pkg::ST_DOUBLE;
          end else begin
            small_stk_d[small_cnt_q[fbpa_pkg::S_IW-1:0]] = small_fidx;
            small_cnt_d              = small_cnt_q + fbpa_pkg::S_CW'(1);
            small_used_d[small_fidx] = 1'b0;
          end
        end else if (in_med) begin
          if ((off_m & 16'(fbpa_pkg::MEDIUM_SIZE - 1)) != '0) begin
            status_d = fbpa_pkg::ST_BAD_ADDR;
          end else if (!med_used_q[med_fidx] ||
                       med_cnt_q >= fbpa_pkg::M_CW'(fbpa_pkg::MEDIUM_BLOCKS)) begin
            status_d = fbpa_pkg::ST_DOUBLE;
          end else begin
            med_stk_d[med_cnt_q[fbpa_pkg::M_IW-1:0]] = med_fidx;
            med_cnt_d            = med_cnt_q + fbpa_pkg::M_CW'(1);
            med_used_d[med_fidx] = 1'b0;
          end
        end else if (in_large) begin
          if ((off_l & 16'(fbpa_pkg::LARGE_SIZE - 1)) != '0) begin
            status_d = fbpa_pkg::ST_BAD_ADDR;
          end else if (!large_used_q[large_fidx] ||
                       large_cnt_q >= fbpa_pkg::L_CW'(fbpa_pkg::LARGE_BLOCKS)) begin
            status_d = fbpa_pkg::ST_DOUBLE;
          end else begin
            large_stk_d[large_cnt_q[fbpa_pkg::L_IW-1:0]] = large_fidx;
            large_cnt_d              = large_cnt_q + fbpa_pkg::L_CW'(1);
            large_used_d[large_fidx] = 1'b0;
          end
        end else begin
          status_d = fbpa_pkg::ST_BAD_ADDR;
        end
      end
      default: begin
        status_d = fbpa_pkg::ST_BAD_ADDR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
    end else if (cfg_we_i) begin
      base_q <= cfg_wdata_i;
    end
  end

  // request register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      s1_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      cmd_q  <= fbpa_pkg::cmd_e'(req_i.command);
      size_q <= req_i.request_size;
      rel_q  <= req_i.release_address;
    end
  end

  // response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s1_adv) begin
      addr_q   <= addr_d;
      status_q <= status_d;
    end
  end

  // free stacks, counts and in-use bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < fbpa_pkg::SMALL_BLOCKS; i++) begin
        small_stk_q[i] <= fbpa_pkg::S_IW'(fbpa_pkg::SMALL_BLOCKS - 1 - i);
      end
      for (int i = 0; i < fbpa_pkg::MEDIUM_BLOCKS; i++) begin
        med_stk_q[i] <= fbpa_pkg::M_IW'(fbpa_pkg::MEDIUM_BLOCKS - 1 - i);
      end
      for (int i = 0; i < fbpa_pkg::LARGE_BLOCKS; i++) begin
        large_stk_q[i] <= fbpa_pkg::L_IW'(fbpa_pkg::LARGE_BLOCKS - 1 - i);
      end
      small_cnt_q  <= fbpa_pkg::S_CW'(fbpa_pkg::SMALL_BLOCKS);
      med_cnt_q    <= fbpa_pkg::M_CW'(fbpa_pkg::MEDIUM_BLOCKS);
      large_cnt_q  <= fbpa_pkg::L_CW'(fbpa_pkg::LARGE_BLOCKS);
      small_used_q <= '0;
      med_used_q   <= '0;
      large_used_q <= '0;
    end else if (s1_valid_q && s1_adv) begin
      small_stk_q  <= small_stk_d;
      med_stk_q    <= med_stk_d;
      large_stk_q  <= large_stk_d;
      small_cnt_q  <= small_cnt_d;
      med_cnt_q    <= med_cnt_d;
      large_cnt_q  <= large_cnt_d;
      small_used_q <= small_used_d;
      med_used_q   <= med_used_d;
      large_used_q <= large_used_d;
    end
  end

  a_err_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (status_q != fbpa_pkg::ST_OK) |-> addr_q == '0)
    else $error("nonzero payload address on error response");

  a_small_balance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(small_cnt_q) + $countones(small_used_q) == fbpa_pkg::SMALL_BLOCKS)
    else $error("small pool free count and in-use bits disagree");

  a_med_balance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(med_cnt_q) + $countones(med_used_q) == fbpa_pkg::MEDIUM_BLOCKS)
    else $error("medium pool free count and in-use bits disagree");

  a_large_balance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(large_cnt_q) + $countones(large_used_q) == fbpa_pkg::LARGE_BLOCKS)
    else $error("large pool free count and in-use bits disagree");

endmodule

// ===== test/fbpa_alloc_checker.sv =====
// Checker for the block pool allocator: predicts each response and compares it field by field
module fbpa_alloc_checker
  import fbpa_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  fbpa_req_if         req,
  fbpa_rsp_if         rsp,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_POOLS    = 3;
  localparam int POOL_NONE    = -1;
  localparam int TOTAL_BLOCKS = SMALL_BLOCKS + MEDIUM_BLOCKS + LARGE_BLOCKS;

  localparam int POOL_BLOCKS [NUM_POOLS] = '{SMALL_BLOCKS, MEDIUM_BLOCKS, LARGE_BLOCKS};
  localparam int POOL_BYTES  [NUM_POOLS] = '{SMALL_SIZE, MEDIUM_SIZE, LARGE_SIZE};
  localparam int POOL_START  [NUM_POOLS] = '{0, MEDIUM_START, LARGE_START};
  localparam int POOL_MARK   [NUM_POOLS] = '{0, SMALL_BLOCKS, SMALL_BLOCKS + MEDIUM_BLOCKS};

  typedef struct packed {
    logic [15:0] payload_address;
    status_e     status;
  } alloc_rsp_t;

  logic [15:0] base_addr;
  int          free_stk [NUM_POOLS][TOTAL_BLOCKS];
  int          free_cnt [NUM_POOLS];
  bit          in_use   [TOTAL_BLOCKS];
  alloc_rsp_t  pending_rsp_q[$];
  alloc_rsp_t  want;

  initial fail_count_o = 0;

  function automatic void reset_pools();
    int p;
    int i;
    base_addr = '0;
    for (p = 0; p < NUM_POOLS; p++) begin
      for (i = 0; i < POOL_BLOCKS[p]; i++) begin
        free_stk[p][i] = POOL_BLOCKS[p] - 1 - i;
      end
      free_cnt[p] = POOL_BLOCKS[p];
    end
    for (i = 0; i < TOTAL_BLOCKS; i++) begin
      in_use[i] = 1'b0;
    end
  endfunction

  function automatic alloc_rsp_t apply_request(logic cmd, logic signed [15:0] sz,
                                               logic [15:0] ra);
    alloc_rsp_t  r;
    int          p;
    int          q;
    int          idx;
    int          rel;
    int          mark;
    logic [15:0] off;
    r.payload_address = '0;
    r.status          = ST_OK;
    p                 = POOL_NONE;
    if (cmd == CMD_ALLOC) begin
      if (sz <= SMALL_PAYLOAD) begin
        p = 0;
      end else if (sz <= MEDIUM_PAYLOAD) begin
        p = 1;
      end else if (sz <= LARGE_PAYLOAD) begin
        p = 2;
      end
      if (p == POOL_NONE) begin
        r.status = ST_TOO_LARGE;
      end else if (free_cnt[p] == 0) begin
        r.status = ST_EXHAUSTED;
      end else begin
        free_cnt[p]--;
        idx = free_stk[p][free_cnt[p]];
        in_use[POOL_MARK[p] + idx] = 1'b1;
        r.payload_address = base_addr + 16'(POOL_START[p] + idx * POOL_BYTES[p] + HEADER_BYTES);
      end
    end else begin
      off = ra - base_addr - 16'(HEADER_BYTES);
      for (q = 0; q < NUM_POOLS; q++) begin
        if (p == POOL_NONE && int'(off) >= POOL_START[q] &&
            int'(off) < POOL_START[q] + POOL_BLOCKS[q] * POOL_BYTES[q]) begin
          p = q;
        end
      end
      if (p == POOL_NONE) begin
        r.status = ST_BAD_ADDR;
      end else begin
        rel = int'(off) - POOL_START[p];
        idx = rel / POOL_BYTES[p];
        mark = POOL_MARK[p] + idx;
        if (rel % POOL_BYTES[p] != 0) begin
          r.status = ST_BAD_ADDR;
        end else if (!in_use[mark] || free_cnt[p] >= POOL_BLOCKS[p]) begin
          r.status = ST_DOUBLE;
        end else begin
          free_stk[p][free_cnt[p]] = idx;
          free_cnt[p]++;
          in_use[mark] = 1'b0;
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] exp_val);
    $display("%0t: mismatch on %s: got 0x%04h, expected 0x%04h", $time, what, got, exp_val);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_pools();
      pending_rsp_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        base_addr = cfg_wdata_i;
      end
      if (rsp.valid && rsp.ready) begin
        if (pending_rsp_q.size() == 0) begin
          report_mismatch("unexpected response", rsp.payload_address, '0);
        end else begin
          want = pending_rsp_q.pop_front();
          if (rsp.payload_address !== want.payload_address) begin
            report_mismatch("payload_address", rsp.payload_address, want.payload_address);
          end
          if (rsp.status !== want.status) begin
            report_mismatch("status", 16'(rsp.status), 16'(want.status));
          end
        end
      end
      if (req.valid && req.ready) begin
        pending_rsp_q.push_back(apply_request(req.command, req.request_size,
                                              req.release_address));
      end
      pending_o <= pending_rsp_q.size();
    end
  end

endmodule

// ===== test/fixed_block_pool_allocator_tb.sv =====
// Testbench top for the block pool allocator: clock, reset, stimulus, watchdog and verdict
module fixed_block_pool_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fbpa_pkg::*;

  localparam int QUIET_LIMIT     = 2000;
  localparam int ITEMS_PER_PHASE = 190;
  localparam int NUM_PHASES      = 5;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;
  int          fail_count;
  int          pending_results;
  int          quiet_cycles = 0;
  bit          bursty;

  fbpa_req_if req ();
  fbpa_rsp_if rsp ();

  fixed_block_pool_allocator u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req),
    .rsp_o       (rsp)
  );

  fbpa_alloc_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .req          (req),
    .rsp          (rsp),
    .fail_count_o (fail_count),
    .pending_o    (pending_results)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [15:0] payload_of(logic [15:0] base, int k);
    int start;
    if (k < SMALL_BLOCKS) begin
      start = k * SMALL_SIZE;
    end else if (k < SMALL_BLOCKS + MEDIUM_BLOCKS) begin
      start = MEDIUM_START + (k - SMALL_BLOCKS) * MEDIUM_SIZE;
    end else begin
      start = LARGE_START + (k - SMALL_BLOCKS - MEDIUM_BLOCKS) * LARGE_SIZE;
    end
    return base + 16'(start + HEADER_BYTES);
  endfunction

  task automatic send_request(cmd_e c, logic signed [15:0] sz, logic [15:0] ra);
    if (bursty && $urandom_range(0, 6) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    req.valid           <= 1'b1;
    req.command         <= c;
    req.request_size    <= sz;
    req.release_address <= ra;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    req.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
  endtask

  task automatic write_base(logic [15:0] value);
    wait_drained();
    repeat (3) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic send_random(int alloc_pct, logic [15:0] base);
    logic signed [15:0] sz;
    logic        [15:0] ra;
    ra = payload_of(base, $urandom_range(0, SMALL_BLOCKS + MEDIUM_BLOCKS + LARGE_BLOCKS - 1));
    case ($urandom_range(0, 9))
      0: ra = 16'($urandom);
      1: ra = ra + 16'($urandom_range(1, SMALL_SIZE - 1));
      default: ;
    endcase
    case ($urandom_range(0, 9))
      0: sz = 16'($urandom);
      1: sz = 16'($urandom) | 16'h8000;
      2, 3: begin
        case ($urandom_range(0, 5))
          0: sz = SMALL_PAYLOAD;
          1: sz = SMALL_PAYLOAD + 16'sd1;
          2: sz = MEDIUM_PAYLOAD;
          3: sz = MEDIUM_PAYLOAD + 16'sd1;
          4: sz = LARGE_PAYLOAD;
          default: sz = LARGE_PAYLOAD + 16'sd1;
        endcase
      end
      default: sz = 16'($urandom_range(0, LARGE_SIZE));
    endcase
    if ($urandom_range(0, 99) < alloc_pct) begin
      send_request(CMD_ALLOC, sz, ra);
    end else begin
      send_request(CMD_FREE, sz, ra);
    end
  endtask

  initial begin
    rsp.ready <= 1'b0;
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      if (bursty && $urandom_range(0, 5) == 0) begin
        rsp.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end
      rsp.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int ph;
    int n;
    int alloc_pct;
    logic [15:0] base;
    req.valid           <= 1'b0;
    req.command         <= CMD_ALLOC;
    req.request_size    <= '0;
    req.release_address <= '0;
    cfg_we_i            <= 1'b0;
    cfg_wdata_i         <= '0;
    rst_ni              <= 1'b0;
    bursty              = 1'b1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(CMD_ALLOC, 16'sh8000, '0);
    send_request(CMD_ALLOC, 16'sd0, '0);
    send_request(CMD_ALLOC, SMALL_PAYLOAD, '0);
    send_request(CMD_ALLOC, SMALL_PAYLOAD + 16'sd1, '0);
    send_request(CMD_ALLOC, MEDIUM_PAYLOAD, '0);
    send_request(CMD_ALLOC, MEDIUM_PAYLOAD + 16'sd1, '0);
    send_request(CMD_ALLOC, LARGE_PAYLOAD, '0);
    send_request(CMD_ALLOC, LARGE_PAYLOAD + 16'sd1, '0);
    send_request(CMD_ALLOC, 16'sh7FFF, '0);
    send_request(CMD_FREE, '0, payload_of('0, 0));
    send_request(CMD_FREE, '0, payload_of('0, 0));
    send_request(CMD_FREE, '0, payload_of('0, 0) + 16'd1);
    send_request(CMD_FREE, '0, 16'h0000);
    send_request(CMD_FREE, '0, 16'hFFFF);
    send_request(CMD_FREE, '0, payload_of('0, SMALL_BLOCKS));
    send_request(CMD_FREE, '0, payload_of('0, SMALL_BLOCKS + MEDIUM_BLOCKS + LARGE_BLOCKS - 1));
    send_request(CMD_FREE, '0, 16'(TOTAL_AREA + HEADER_BYTES));
    repeat (3) send_request(CMD_ALLOC, LARGE_PAYLOAD, '0);

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin base = 16'hFFFF; alloc_pct = 60; end
        1: begin base = 16'($urandom); alloc_pct = 45; end
        2: begin base = 16'hFF80; alloc_pct = 75; end
        3: begin base = 16'h0000; alloc_pct = 35; end
        default: begin base = 16'h8001; alloc_pct = 55; end
      endcase
      write_base(base);
      bursty = (ph != 2) && (ph != NUM_PHASES - 1);
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (ph == 1 && n == ITEMS_PER_PHASE / 2) begin
          wait_drained();
        end
        send_random(alloc_pct, base);
      end
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
